/* hw/rtl/lvv_pkg.sv */
// lvv_pkg: types, codes and fixed-point constants for the lumped vertex volume block
// no dependencies; imported by the channel interfaces and the top module
`default_nettype none
package lvv_pkg;

  localparam int CFG_W = 2;

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_ELEM   = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_INVERTED = 2'd1;
  localparam logic [1:0] ST_THICK    = 2'd2;
  localparam logic [1:0] ST_SAT      = 2'd3;

  localparam logic [1:0] DIM_POINT = 2'd0;
  localparam logic [1:0] DIM_EDGE  = 2'd1;
  localparam logic [1:0] DIM_TRI   = 2'd2;
  localparam logic [1:0] DIM_TET   = 2'd3;

  localparam logic [0:0] REG_DIMENSION = 1'b0;
  localparam logic [0:0] REG_THICKNESS = 1'b1;

  localparam logic [62:0] VOL_MAX   = 63'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [62:0] ONE_Q24   = 63'd16777216;
  localparam logic [48:0] PI_Q24    = 49'd52707179;
  localparam logic [48:0] FTPI_Q24  = 49'd70276238;

  typedef struct packed {
    logic [1:0]         operation;
    logic [9:0]         vertex_index;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic [14:0]        vertex_thickness;
    logic [9:0]         corner_a;
    logic [9:0]         corner_b;
    logic [9:0]         corner_c;
    logic [9:0]         corner_d;
  } req_item_t;

  typedef struct packed {
    logic [62:0] vertex_volume;
    logic [1:0]  status;
  } rsp_item_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic [14:0]        th;
  } vertex_t;

endpackage
`default_nettype wire

/* hw/rtl/lvv_if.sv */
// lvv_if: valid/ready channel interfaces for request and response items
// depends on lvv_pkg
`default_nettype none
interface lvv_req_if;
  import lvv_pkg::*;
  logic      valid;
  logic      ready;
  req_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lvv_rsp_if;
  import lvv_pkg::*;
  logic      valid;
  logic      ready;
  rsp_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* hw/rtl/lvv_mul.sv */
// lvv_mul: iterative signed multiplier, 48x16 bits per cycle, three passes
// no package dependencies
`default_nettype none
module lvv_mul (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [48:0] a,
  input  logic signed [48:0] b,
  output logic [95:0]        mag,
  output logic               neg,
  output logic               done
);
  logic [47:0] am;
  logic [47:0] bm;
  logic [1:0]  cnt;
  logic        busy;
  logic [48:0] aa;
  logic [48:0] ba;
  logic [63:0] pp;

  assign aa = a[48] ? 49'(-a) : 49'(a);
  assign ba = b[48] ? 49'(-b) : 49'(b);
  assign pp = {16'b0, am} * {48'b0, bm[47:32]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        am   <= aa[47:0];
        bm   <= ba[47:0];
        neg  <= a[48] ^ b[48];
        mag  <= '0;
        cnt  <= 2'd2;
        busy <= 1'b1;
      end else if (busy) begin
        mag <= {mag[79:0], 16'b0} + {32'b0, pp};
        bm  <= {bm[31:0], 16'b0};
        cnt <= cnt - 2'd1;
        if (cnt == 2'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/lvv_sqrt.sv */
// lvv_sqrt: restoring integer square root, one result bit per cycle
// no package dependencies
`default_nettype none
module lvv_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [87:0] rad,
  output logic [43:0] root,
  output logic        done
);
  logic [87:0] x;
  logic [45:0] rem;
  logic [5:0]  cnt;
  logic        busy;
  logic [47:0] rem2;
  logic [47:0] trial;
  logic        ge;

  assign rem2  = {rem, x[87:86]};
  assign trial = {2'b0, root, 2'b01};
  assign ge    = rem2 >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        x    <= rad;
        rem  <= '0;
        root <= '0;
        cnt  <= 6'd43;
        busy <= 1'b1;
      end else if (busy) begin
        rem  <= ge ? 46'(rem2 - trial) : rem2[45:0];
        root <= {root[42:0], ge};
        x    <= {x[85:0], 2'b0};
        cnt  <= cnt - 6'd1;
        if (cnt == 6'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/lvv_div3.sv */
// lvv_div3: divide by three, four quotient bits per cycle
// no package dependencies
`default_nettype none
module lvv_div3 (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] num,
  output logic [63:0] quo,
  output logic        done
);
  logic [63:0] n;
  logic [1:0]  rem;
  logic [3:0]  cnt;
  logic        busy;
  logic [63:0] nn;
  logic [63:0] qq;
  logic [1:0]  rr;

  always_comb begin
    logic [2:0] r3;
    nn = n;
    qq = quo;
    rr = rem;
    for (int i = 0; i < 4; i++) begin
      r3 = {rr, nn[63]};
      nn = {nn[62:0], 1'b0};
      if (r3 >= 3'd3) begin
        qq = {qq[62:0], 1'b1};
        rr = 2'(r3 - 3'd3);
      end else begin
        qq = {qq[62:0], 1'b0};
        rr = r3[1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        n    <= num;
        quo  <= '0;
        rem  <= '0;
        cnt  <= 4'd15;
        busy <= 1'b1;
      end else if (busy) begin
        n   <= nn;
        quo <= qq;
        rem <= rr;
        cnt <= cnt - 4'd1;
        if (cnt == 4'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/lumped_vertex_volume_top.sv */
// lumped_vertex_volume_top: vertex store with lumped volume accumulation per element
// depends on lvv_pkg, lvv_if, lvv_mul, lvv_sqrt, lvv_div3
//
// usage: items enter on req (valid/ready), one result item per request leaves on rsp.
// config writes (cfg_we, cfg_index, cfg_data) must come only while the block is idle; the block does not check.
// one item is processed at a time; req.ready is high only when the sequencer is idle.
// a read steps through S_RRD and S_RWT, a plain load through S_LOAD and S_LDW, and a
// point load with thickness adds three multiplies. elements: vertex reads, then the
// multiplies on the shared 48x16 multiplier (9 for tets, 9 or 10 for triangles, 3 or 6
// for edges), a bit-serial square root for triangles and edges, a divide by three for
// tets and triangles, and an accumulator read-modify-write per corner.
// the vertex and volume memories have registered reads; an accumulator update is written
// before the next corner is read, so repeated corners accumulate correctly.
// reset sets dimension to tetrahedra and clears control state; memory contents are not
// cleared, a vertex must be loaded before use. a stalled rsp holds its item; the next
// request is accepted meanwhile and its result waits until the output register frees.
`default_nettype none
module lumped_vertex_volume_top #(
  parameter int VERTEX_COUNT = 1024
) (
  input  logic                      clk,
  input  logic                      rst,
  lvv_req_if.sink                   req,
  lvv_rsp_if.source                 rsp,
  input  logic                      cfg_we,
  input  logic [0:0]                cfg_index,
  input  logic [lvv_pkg::CFG_W-1:0] cfg_data
);
  import lvv_pkg::*;

  localparam int AW = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;

  typedef enum logic [15:0] {
    S_IDLE = 16'b0000_0000_0000_0001,
    S_LOAD = 16'b0000_0000_0000_0010,
    S_LDW  = 16'b0000_0000_0000_0100,
    S_VRD  = 16'b0000_0000_0000_1000,
    S_CHK  = 16'b0000_0000_0001_0000,
    S_MUL  = 16'b0000_0000_0010_0000,
    S_MWT  = 16'b0000_0000_0100_0000,
    S_SQS  = 16'b0000_0000_1000_0000,
    S_SQW  = 16'b0000_0001_0000_0000,
    S_DVS  = 16'b0000_0010_0000_0000,
    S_DVW  = 16'b0000_0100_0000_0000,
    S_ARD  = 16'b0000_1000_0000_0000,
    S_AWR  = 16'b0001_0000_0000_0000,
    S_RRD  = 16'b0010_0000_0000_0000,
    S_RWT  = 16'b0100_0000_0000_0000,
    S_DONE = 16'b1000_0000_0000_0000
  } state_t;

  function automatic logic [AW-1:0] slot(input logic [9:0] v);
    logic [9:0] rv;
    rv = v;
    for (int j = 9; j >= 0; j--) begin
      if ((longint'(VERTEX_COUNT) << j) <= 64'sd1023) begin
        if (longint'(rv) >= (longint'(VERTEX_COUNT) << j)) begin
          rv = rv - 10'(longint'(VERTEX_COUNT) << j);
        end
      end
    end
    return AW'(rv);
  endfunction

  state_t             state;
  logic [1:0]         dim;
  logic               th_en;
  req_item_t          item;
  logic [AW-1:0]      vidx;
  logic [AW-1:0]      ca [4];
  logic signed [15:0] px [4];
  logic signed [15:0] py [4];
  logic signed [15:0] pz [4];
  logic [14:0]        th [4];
  logic [2:0]         rk;
  logic [1:0]         k;
  logic [3:0]         ms;
  logic signed [48:0] t;
  logic signed [48:0] m;
  logic signed [55:0] d;
  logic [71:0]        s;
  logic [63:0]        val;
  logic [63:0]        dnum;
  logic [62:0]        share;
  logic               sat;
  logic [14:0]        r;
  logic [62:0]        res_vol;
  logic [1:0]         res_st;
  logic               out_valid;
  rsp_item_t          out_item;

  vertex_t            vmem [VERTEX_COUNT];
  vertex_t            vrd;
  logic [62:0]        volmem [VERTEX_COUNT];
  logic [62:0]        vol_rd;
  logic               vol_we;
  logic [AW-1:0]      vol_wa;
  logic [AW-1:0]      vol_ra;
  logic [62:0]        vol_wd;
  logic [63:0]        acc_sum;

  logic signed [16:0] ax, ay, az, bx, by, bz, cx, cy, cz;
  logic signed [48:0] opa, opb;
  logic               mul_start, mul_done, mul_neg;
  logic [95:0]        mul_mag;
  logic signed [96:0] p_s;
  logic signed [48:0] p49;
  logic signed [55:0] p56;
  logic signed [55:0] dnew;
  logic [62:0]        q24;
  logic               sqrt_start, sqrt_done;
  logic [87:0]        rad;
  logic [43:0]        root;
  logic               div_start, div_done;
  logic [63:0]        quo;

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = out_valid;
  assign rsp.data  = out_item;

  assign ax = 17'(px[1]) - 17'(px[0]);
  assign ay = 17'(py[1]) - 17'(py[0]);
  assign az = 17'(pz[1]) - 17'(pz[0]);
  assign bx = 17'(px[2]) - 17'(px[0]);
  assign by = 17'(py[2]) - 17'(py[0]);
  assign bz = 17'(pz[2]) - 17'(pz[0]);
  assign cx = 17'(px[3]) - 17'(px[0]);
  assign cy = 17'(py[3]) - 17'(py[0]);
  assign cz = 17'(pz[3]) - 17'(pz[0]);

  // operand selection per sequencer step
  always_comb begin
    opa = '0;
    opb = '0;
    unique case (dim)
      DIM_TET: begin
        case (ms)
          4'd0: begin opa = 49'(by); opb = 49'(cz); end
          4'd1: begin opa = 49'(bz); opb = 49'(cy); end
          4'd2: begin opa = 49'(ax); opb = m; end
          4'd3: begin opa = 49'(ay); opb = 49'(cz); end
          4'd4: begin opa = 49'(az); opb = 49'(cy); end
          4'd5: begin opa = 49'(bx); opb = m; end
          4'd6: begin opa = 49'(ay); opb = 49'(bz); end
          4'd7: begin opa = 49'(az); opb = 49'(by); end
          4'd8: begin opa = 49'(cx); opb = m; end
          default: begin opa = '0; opb = '0; end
        endcase
      end
      DIM_TRI: begin
        case (ms)
          4'd0: begin opa = 49'(ay); opb = 49'(bz); end
          4'd1: begin opa = 49'(az); opb = 49'(by); end
          4'd3: begin opa = 49'(az); opb = 49'(bx); end
          4'd4: begin opa = 49'(ax); opb = 49'(bz); end
          4'd6: begin opa = 49'(ax); opb = 49'(by); end
          4'd7: begin opa = 49'(ay); opb = 49'(bx); end
          4'd2, 4'd5, 4'd8: begin opa = m; opb = m; end
          4'd9: begin
            opa = $signed({1'b0, val[47:0]});
            opb = $signed({34'b0, r});
          end
          default: begin opa = '0; opb = '0; end
        endcase
      end
      DIM_EDGE: begin
        case (ms)
          4'd0: begin opa = 49'(ax); opb = 49'(ax); end
          4'd1: begin opa = 49'(ay); opb = 49'(ay); end
          4'd2: begin opa = 49'(az); opb = 49'(az); end
          4'd3: begin opa = $signed({34'b0, r}); opb = $signed({34'b0, r}); end
          4'd4: begin opa = t; opb = $signed(PI_Q24); end
          4'd5: begin opa = $signed({1'b0, val[47:0]}); opb = t; end
          default: begin opa = '0; opb = '0; end
        endcase
      end
      DIM_POINT: begin
        case (ms)
          4'd0: begin opa = $signed({34'b0, r}); opb = $signed({34'b0, r}); end
          4'd1: begin opa = t; opb = $signed({34'b0, r}); end
          4'd2: begin opa = t; opb = $signed(FTPI_Q24); end
          default: begin opa = '0; opb = '0; end
        endcase
      end
      default: begin opa = '0; opb = '0; end
    endcase
  end

  assign p_s  = mul_neg ? -$signed({1'b0, mul_mag}) : $signed({1'b0, mul_mag});
  assign p49  = p_s[48:0];
  assign p56  = p_s[55:0];
  assign dnew = d + p56;
  assign q24  = (|mul_mag[95:87]) ? VOL_MAX : mul_mag[86:24];
  assign rad  = (dim == DIM_TRI) ? {s, 16'b0} : {s[55:0], 32'b0};

  assign mul_start  = (state == S_MUL);
  assign sqrt_start = (state == S_SQS);
  assign div_start  = (state == S_DVS);

  lvv_mul u_mul (
    .clk, .rst, .start(mul_start), .a(opa), .b(opb),
    .mag(mul_mag), .neg(mul_neg), .done(mul_done)
  );

  lvv_sqrt u_sqrt (
    .clk, .rst, .start(sqrt_start), .rad, .root, .done(sqrt_done)
  );

  lvv_div3 u_div3 (
    .clk, .rst, .start(div_start), .num(dnum), .quo, .done(div_done)
  );

  // vertex memory
  always_ff @(posedge clk) begin
    if (state == S_LOAD) begin
      vmem[vidx] <= '{x: item.pos_x, y: item.pos_y, z: item.pos_z,
                      th: item.vertex_thickness};
    end
    vrd <= vmem[ca[rk[1:0]]];
  end

  // volume memory
  assign acc_sum = {1'b0, vol_rd} + {1'b0, share};
  assign vol_we  = (state == S_LDW) || (state == S_AWR);
  assign vol_wa  = (state == S_LDW) ? vidx : ca[k];
  assign vol_ra  = (state == S_RRD) ? vidx : ca[k];
  assign vol_wd  = (state == S_LDW) ? val[62:0] : (acc_sum[63] ? VOL_MAX : acc_sum[62:0]);

  always_ff @(posedge clk) begin
    if (vol_we) begin
      volmem[vol_wa] <= vol_wd;
    end
    vol_rd <= volmem[vol_ra];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      dim       <= DIM_TET;
      th_en     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_DIMENSION: dim <= cfg_data;
          REG_THICKNESS: th_en <= cfg_data[0];
          default: ;
        endcase
      end
      if (rsp.valid && rsp.ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            item    <= req.data;
            vidx    <= slot(req.data.vertex_index);
            ca[0]   <= slot(req.data.corner_a);
            ca[1]   <= slot(req.data.corner_b);
            ca[2]   <= slot(req.data.corner_c);
            ca[3]   <= slot(req.data.corner_d);
            rk      <= '0;
            k       <= '0;
            ms      <= '0;
            sat     <= 1'b0;
            res_vol <= '0;
            res_st  <= ST_OK;
            unique case (req.data.operation)
              OP_LOAD: state <= S_LOAD;
              OP_READ: state <= S_RRD;
              OP_ELEM: state <= (dim == DIM_POINT) ? S_DONE : S_VRD;
              default: state <= S_DONE;
            endcase
          end
        end
        S_LOAD: begin
          r <= item.vertex_thickness;
          if (dim == DIM_POINT && th_en && item.vertex_thickness != 15'd0) begin
            ms    <= '0;
            state <= S_MUL;
          end else begin
            val   <= (dim == DIM_POINT) ? {1'b0, ONE_Q24} : 64'd0;
            state <= S_LDW;
          end
        end
        S_LDW: begin
          res_vol <= val[62:0];
          state   <= S_DONE;
        end
        S_RRD: state <= S_RWT;
        S_RWT: begin
          res_vol <= vol_rd;
          state   <= S_DONE;
        end
        S_VRD: begin
          if (rk != 3'd0) begin
            px[2'(rk - 3'd1)] <= vrd.x;
            py[2'(rk - 3'd1)] <= vrd.y;
            pz[2'(rk - 3'd1)] <= vrd.z;
            th[2'(rk - 3'd1)] <= vrd.th;
          end
          if (rk == 3'd4) begin
            state <= S_CHK;
          end else begin
            rk <= rk + 3'd1;
          end
        end
        S_CHK: begin
          r  <= th_en ? th[0] : 15'd0;
          ms <= '0;
          if (th_en && dim != DIM_TET &&
              (th[1] != th[0] || (dim == DIM_TRI && th[2] != th[0]))) begin
            res_st <= ST_THICK;
            state  <= S_DONE;
          end else begin
            state <= S_MUL;
          end
        end
        S_MUL: state <= S_MWT;
        S_MWT: begin
          if (mul_done) begin
            ms <= ms + 4'd1;
            unique case (dim)
              DIM_TET: begin
                case (ms)
                  4'd0, 4'd3, 4'd6: begin
                    t     <= p49;
                    state <= S_MUL;
                  end
                  4'd1, 4'd4, 4'd7: begin
                    m     <= t - p49;
                    state <= S_MUL;
                  end
                  4'd2: begin
                    d     <= p56;
                    state <= S_MUL;
                  end
                  4'd5: begin
                    d     <= d - p56;
                    state <= S_MUL;
                  end
                  default: begin
                    if (dnew <= 56'sd0) begin
                      res_st <= ST_INVERTED;
                      state  <= S_DONE;
                    end else begin
                      dnum  <= {11'b0, dnew[55:3]};
                      state <= S_DVS;
                    end
                  end
                endcase
              end
              DIM_TRI: begin
                case (ms)
                  4'd0, 4'd3, 4'd6: begin
                    t     <= p49;
                    state <= S_MUL;
                  end
                  4'd1, 4'd4, 4'd7: begin
                    m     <= t - p49;
                    state <= S_MUL;
                  end
                  4'd2: begin
                    s     <= mul_mag[71:0];
                    state <= S_MUL;
                  end
                  4'd5: begin
                    s     <= s + mul_mag[71:0];
                    state <= S_MUL;
                  end
                  4'd8: begin
                    s     <= s + mul_mag[71:0];
                    state <= S_SQS;
                  end
                  default: begin
                    dnum  <= mul_mag[70:7];
                    state <= S_DVS;
                  end
                endcase
              end
              DIM_EDGE: begin
                case (ms)
                  4'd0: begin
                    s     <= mul_mag[71:0];
                    state <= S_MUL;
                  end
                  4'd1: begin
                    s     <= s + mul_mag[71:0];
                    state <= S_MUL;
                  end
                  4'd2: begin
                    s     <= s + mul_mag[71:0];
                    state <= S_SQS;
                  end
                  4'd3: begin
                    t     <= p49;
                    state <= S_MUL;
                  end
                  4'd4: begin
                    t     <= $signed({1'b0, mul_mag[63:16]});
                    state <= S_MUL;
                  end
                  default: begin
                    share <= {1'b0, q24[62:1]};
                    k     <= '0;
                    state <= S_ARD;
                  end
                endcase
              end
              DIM_POINT: begin
                case (ms)
                  4'd0, 4'd1: begin
                    t     <= p49;
                    state <= S_MUL;
                  end
                  default: begin
                    val   <= {1'b0, q24};
                    state <= S_LDW;
                  end
                endcase
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_SQS: state <= S_SQW;
        S_SQW: begin
          if (sqrt_done) begin
            if (dim == DIM_TRI) begin
              val <= {21'b0, root[43:1]};
              if (r != 15'd0) begin
                ms    <= 4'd9;
                state <= S_MUL;
              end else begin
                dnum  <= {21'b0, root[43:1]};
                state <= S_DVS;
              end
            end else begin
              val <= {20'b0, root};
              if (r != 15'd0) begin
                ms    <= 4'd3;
                state <= S_MUL;
              end else begin
                share <= {20'b0, root[43:1]};
                k     <= '0;
                state <= S_ARD;
              end
            end
          end
        end
        S_DVS: state <= S_DVW;
        S_DVW: begin
          if (div_done) begin
            share <= quo[62:0];
            k     <= '0;
            state <= S_ARD;
          end
        end
        S_ARD: state <= S_AWR;
        S_AWR: begin
          if (acc_sum[63]) begin
            sat <= 1'b1;
          end
          if (k == dim) begin
            res_st <= (sat || acc_sum[63]) ? ST_SAT : ST_OK;
            state  <= S_DONE;
          end else begin
            k     <= k + 2'd1;
            state <= S_ARD;
          end
        end
        S_DONE: begin
          if (!out_valid || rsp.ready) begin
            out_valid <= 1'b1;
            out_item  <= '{vertex_volume: res_vol, status: res_st};
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_mul_done_waited: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> state == S_MWT) else $error("multiplier result with no waiting step");
  a_sqrt_done_waited: assert property (@(posedge clk) disable iff (rst)
    sqrt_done |-> state == S_SQW) else $error("square root result with no waiting step");
  a_div_done_waited: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DVW) else $error("divide result with no waiting step");
  a_rmw_order: assert property (@(posedge clk) disable iff (rst)
    state == S_AWR |-> $past(state) == S_ARD) else $error("accumulator write without read");

endmodule
`default_nettype wire
